[src/sprw_pkg.sv]
// Shared types and constants for the sprite pixel walker.
// No dependencies; used by sprite_pixel_walker and its checker.
package sprw_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int POS_W       = 18;
  localparam int ADDR_W      = 25;

  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_MIN_X = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_MAX_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_MIN_Y = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_MAX_Y = 3'd5;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // scroll registers carry a fixed hardware bias
  localparam logic [POS_W-1:0] SCROLL_X_BIAS = 18'h00184;
  localparam logic [POS_W-1:0] SCROLL_Y_BIAS = 18'h001f1;

  typedef struct packed {
    logic [7:0]  dest_priority;
    logic [7:0]  gfx_byte;
    logic [15:0] ypos_word;
    logic [15:0] xpos_word;
    logic [15:0] tile_word;
    logic [15:0] attr_word;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic [POS_W-1:0]  next_y;
    logic [POS_W-1:0]  next_x;
    logic [ADDR_W-1:0] next_address;
    logic              more;
    logic [9:0]        write_colour;
    logic [POS_W-1:0]  write_y;
    logic [POS_W-1:0]  write_x;
    logic              write_enable;
  } out_word_t;

endpackage

[src/sprite_pixel_walker.sv]
// Sprite pixel walker: decodes one sprite header, then walks its pixels.
// Depends on sprw_pkg for word layouts, register indexes and constants.
//
// A header word (tuser 0) loads a sprite and returns the first pixel's nibble
// address and screen position; each pixel word (tuser 1) brings back the
// graphics byte and stored priority for that position and returns the write
// decision plus the next announcement, with tlast set when the sprite ends.
// Every word yields exactly one result word. Throughput is one word per
// cycle while m_tready does not stall the result; each word passes the input
// register, then the result register, with a single sprite state update per word.
// Configuration writes are taken any time but are meant for idle periods.
module sprite_pixel_walker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sprw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sprw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // attr_word, tile_word, xpos_word, ypos_word, gfx_byte, dest_priority
  input  logic [79:0]                    s_tdata,
  // kind
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // write_enable, write_x, write_y, write_colour, more, next_address,
  // next_x, next_y, zero pad
  output logic [111:0]                   m_tdata,
  output logic                           m_tlast
);

  logic [15:0] scroll_x_reg, scroll_y_reg;
  logic [9:0]  clip_min_x, clip_max_x, clip_min_y, clip_max_y;

  logic              in_valid;
  logic              in_kind;
  sprw_pkg::in_word_t in_data;
  logic              out_valid;
  logic              out_last;
  sprw_pkg::out_word_t out_data;

  logic [5:0]  colour_bank, colour_bank_next;
  logic [1:0]  sprite_priority, sprite_priority_next;
  logic        flip_x, flip_x_next, flip_y, flip_y_next;
  logic [9:0]  origin_x, origin_x_next, origin_y, origin_y_next;
  logic [7:0]  sprite_width, sprite_width_next, sprite_height, sprite_height_next;
  logic [7:0]  row_count, row_count_next, column_count, column_count_next;
  logic [sprw_pkg::ADDR_W-1:0] nibble_address, nibble_address_next;
  logic        busy, busy_next;

  logic                advance;
  sprw_pkg::out_word_t res;
  logic                res_last;

  logic [sprw_pkg::POS_W-1:0] px, py;
  logic [3:0]  pix;
  logic        in_clip;
  logic [7:0]  col_inc, row_inc;

  function automatic logic [sprw_pkg::POS_W-1:0] screen_pos(
    input logic [9:0]  origin,
    input logic [7:0]  extent,
    input logic [7:0]  count,
    input logic        flip,
    input logic [15:0] scroll,
    input logic [sprw_pkg::POS_W-1:0] bias
  );
    logic [7:0] c;
    c = flip ? (extent - 8'd1 - count) : count;
    return {{8{origin[9]}}, origin} + {10'd0, c} - {2'd0, scroll} + bias;
  endfunction

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x_reg <= '0;
      scroll_y_reg <= '0;
      clip_min_x   <= '0;
      clip_max_x   <= 10'h3ff;
      clip_min_y   <= '0;
      clip_max_y   <= 10'h3ff;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sprw_pkg::REG_SCROLL_X:   scroll_x_reg <= cfg_data;
        sprw_pkg::REG_SCROLL_Y:   scroll_y_reg <= cfg_data;
        sprw_pkg::REG_CLIP_MIN_X: clip_min_x <= cfg_data[9:0];
        sprw_pkg::REG_CLIP_MAX_X: clip_max_x <= cfg_data[9:0];
        sprw_pkg::REG_CLIP_MIN_Y: clip_min_y <= cfg_data[9:0];
        sprw_pkg::REG_CLIP_MAX_Y: clip_max_y <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    colour_bank_next     = colour_bank;
    sprite_priority_next = sprite_priority;
    flip_x_next          = flip_x;
    flip_y_next          = flip_y;
    origin_x_next        = origin_x;
    origin_y_next        = origin_y;
    sprite_width_next    = sprite_width;
    sprite_height_next   = sprite_height;
    row_count_next       = row_count;
    column_count_next    = column_count;
    nibble_address_next  = nibble_address;
    busy_next            = busy;
    res                  = '0;
    res_last             = 1'b0;

    px  = screen_pos(origin_x, sprite_width, column_count, flip_x, scroll_x_reg,
                     sprw_pkg::SCROLL_X_BIAS);
    py  = screen_pos(origin_y, sprite_height, row_count, flip_y, scroll_y_reg,
                     sprw_pkg::SCROLL_Y_BIAS);
    pix = nibble_address[0] ? in_data.gfx_byte[7:4] : in_data.gfx_byte[3:0];
    in_clip = !px[17] && (px >= {8'd0, clip_min_x}) && (px <= {8'd0, clip_max_x}) &&
              !py[17] && (py >= {8'd0, clip_min_y}) && (py <= {8'd0, clip_max_y});
    col_inc = column_count + 8'd1;
    row_inc = row_count + 8'd1;

    if (in_kind == sprw_pkg::KIND_HEADER) begin
      sprite_priority_next = in_data.attr_word[15:14];
      colour_bank_next     = in_data.attr_word[13:8];
      flip_x_next          = in_data.attr_word[7];
      flip_y_next          = in_data.attr_word[6];
      origin_x_next        = in_data.xpos_word[9:0];
      origin_y_next        = in_data.ypos_word[9:0];
      sprite_width_next    = {in_data.xpos_word[15:12], 4'd0};
      sprite_height_next   = {in_data.ypos_word[15:12], 4'd0};
      row_count_next       = '0;
      column_count_next    = '0;
      nibble_address_next  = {1'b0, in_data.tile_word, 8'd0};
      busy_next = !((in_data.ypos_word == in_data.attr_word) ||
                    (in_data.xpos_word[15:12] == 4'd0) ||
                    (in_data.ypos_word[15:12] == 4'd0));
    end else if (busy) begin
      if (in_clip && pix != 4'd0 && in_data.dest_priority < {6'd0, sprite_priority}) begin
        res.write_enable = 1'b1;
        res.write_x      = px;
        res.write_y      = py;
        res.write_colour = {colour_bank, pix};
      end
      nibble_address_next = nibble_address + 1'b1;
      if (col_inc >= sprite_width) begin
        column_count_next = '0;
        row_count_next    = row_inc;
      end else begin
        column_count_next = col_inc;
      end
      if (row_count_next >= sprite_height) begin
        row_count_next = '0;
        busy_next      = 1'b0;
      end
    end

    if (busy_next) begin
      res.more         = 1'b1;
      res.next_address = nibble_address_next;
      res.next_x = screen_pos(origin_x_next, sprite_width_next, column_count_next,
                              flip_x_next, scroll_x_reg, sprw_pkg::SCROLL_X_BIAS);
      res.next_y = screen_pos(origin_y_next, sprite_height_next, row_count_next,
                              flip_y_next, scroll_y_reg, sprw_pkg::SCROLL_Y_BIAS);
    end else begin
      res_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      busy            <= 1'b0;
      colour_bank     <= '0;
      sprite_priority <= '0;
      flip_x          <= 1'b0;
      flip_y          <= 1'b0;
      origin_x        <= '0;
      origin_y        <= '0;
      sprite_width    <= '0;
      sprite_height   <= '0;
      row_count       <= '0;
      column_count    <= '0;
      nibble_address  <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        busy            <= busy_next;
        colour_bank     <= colour_bank_next;
        sprite_priority <= sprite_priority_next;
        flip_x          <= flip_x_next;
        flip_y          <= flip_y_next;
        origin_x        <= origin_x_next;
        origin_y        <= origin_y_next;
        sprite_width    <= sprite_width_next;
        sprite_height   <= sprite_height_next;
        row_count       <= row_count_next;
        column_count    <= column_count_next;
        nibble_address  <= nibble_address_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= sprw_pkg::in_word_t'(s_tdata);
      in_kind <= s_tuser;
    end
    if (advance) begin
      out_data <= res;
      out_last <= res_last;
    end
  end

endmodule

[src/sprw_checker.sv]
// Port-level checks for sprite_pixel_walker, bound to its output ports.
// Depends on sprw_pkg for the result word layout.
module sprw_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic [111:0] m_tdata,
  input logic         m_tlast
);

  sprw_pkg::out_word_t r;
  assign r = sprw_pkg::out_word_t'(m_tdata);

  // every result either announces a next pixel or closes the sprite
  a_more_xor_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (r.more ^ m_tlast))
    else $error("more and last disagree");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !r.write_enable |->
      (r.write_x == '0) && (r.write_y == '0) && (r.write_colour == '0))
    else $error("write fields set without write_enable");

  a_next_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !r.more |->
      (r.next_address == '0) && (r.next_x == '0) && (r.next_y == '0))
    else $error("next fields set without more");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind sprite_pixel_walker sprw_checker u_sprw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
